// File: src/rcr_pkg.sv
// ----------------------------------------------------------------------------
// rcr_pkg
// Shared constants for the rod cutting revenue block.
// ----------------------------------------------------------------------------
package rcr_pkg;

    localparam int MAX_LEN   = 64;
    localparam int PRICE_W   = 16;
    localparam int REV_W     = 22;
    localparam int LEN_W     = 7;
    localparam int CNT_W     = $clog2(MAX_LEN + 1);
    localparam int ADDR_W    = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int IN_DATA_W = 16;
    localparam int OUT_DATA_W = 32;

    localparam logic [REV_W-1:0] REV_MAX = {REV_W{1'b1}};
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(MAX_LEN);

endpackage

// File: src/rod_cutting_revenue_top.sv
// ----------------------------------------------------------------------------
// rod_cutting_revenue_top
// Bottom-up rod cutting: one price per item in, one best revenue per item out.
//
// Input channel s_*: s_tdata[15:0] is the price of the next length; s_tuser
// set starts a new table and makes this price the one for length 1.
// Result channel m_*: m_tdata[21:0] best revenue, m_tdata[28:22] length;
// m_tuser set means the table was full and the item was dropped.
// For length j the block walks i = 1..j, reading one stored price and one
// stored revenue per cycle from two RAMs, each with one write port and one
// registered read port, keeping a running max, then writes r[j] back.
// A dropped item skips the scan and goes straight to the output register.
// One item is in work at a time.
// The finished result sits in an output register; the next item is accepted
// while it waits, and the scan stalls only at the point of loading a new
// result. Reset empties the table and drops any pending result; RAM contents
// need no clearing since only entries below the fill count are read.
// ----------------------------------------------------------------------------
module rod_cutting_revenue_top (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [rcr_pkg::IN_DATA_W-1:0]    s_tdata,   // price
    input  logic                             s_tuser,   // restart
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [rcr_pkg::OUT_DATA_W-1:0]   m_tdata,   // best_revenue, rod_length
    output logic                             m_tuser    // overflow
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_OUT   = 2'd3;

    localparam int CW = rcr_pkg::CNT_W;
    localparam int AW = rcr_pkg::ADDR_W;
    localparam int RW = rcr_pkg::REV_W;
    localparam int PW = rcr_pkg::PRICE_W;

    logic [PW-1:0] price_mem [rcr_pkg::MAX_LEN];
    logic [RW-1:0] rev_mem   [rcr_pkg::MAX_LEN];

    logic [1:0]    state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [CW-1:0] j_reg, j_next;
    logic [CW-1:0] i_reg, i_next;
    logic [RW-1:0] best_reg, best_next;
    logic          ovf_reg, ovf_next;
    logic          rd_vld_reg, rd_vld_next;
    logic          rzero_reg, rzero_next;
    logic          m_valid_reg, m_valid_next;
    logic [RW-1:0] m_rev_reg;
    logic [rcr_pkg::LEN_W-1:0] m_len_reg;
    logic          m_ovf_reg;

    logic [PW-1:0] price_rd_reg;
    logic [RW-1:0] rev_rd_reg;

    logic          accept;
    logic [CW-1:0] base_cnt;
    logic          full;
    logic          price_we;
    logic [AW-1:0] price_waddr;
    logic [AW-1:0] price_raddr;
    logic [CW-1:0] rev_idx;
    logic [AW-1:0] rev_raddr;
    logic          rev_we;
    logic [AW-1:0] rev_waddr;
    logic [RW:0]   sum;
    logic [RW-1:0] cand;
    logic [RW-1:0] best_acc;
    logic          out_free;
    logic          out_load;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign base_cnt = s_tuser ? '0 : cnt_reg;
    assign full     = (base_cnt == rcr_pkg::FULL_CNT);

    assign price_we    = accept && !full;
    assign price_waddr = base_cnt[AW-1:0];
    assign price_raddr = AW'(i_reg - CW'(1));
    assign rev_idx     = j_reg - i_reg - CW'(1);
    assign rev_raddr   = rev_idx[AW-1:0];
    assign rev_we      = (state_reg == ST_DRAIN);
    assign rev_waddr   = AW'(j_reg - CW'(1));

    // candidate p[i] + r[j-i], r[0] = 0, saturating
    assign sum  = {{(RW + 1 - PW){1'b0}}, price_rd_reg}
                + {1'b0, (rzero_reg ? {RW{1'b0}} : rev_rd_reg)};
    assign cand = sum[RW] ? rcr_pkg::REV_MAX : sum[RW-1:0];
    assign best_acc = (rd_vld_reg && (cand > best_reg)) ? cand : best_reg;

    assign out_free = !m_valid_reg || m_tready;
    assign out_load = (state_reg == ST_OUT) && out_free;

    always_ff @(posedge aclk) begin
        if (price_we) begin
            price_mem[price_waddr] <= s_tdata[PW-1:0];
        end
        price_rd_reg <= price_mem[price_raddr];
    end

    always_ff @(posedge aclk) begin
        if (rev_we) begin
            rev_mem[rev_waddr] <= best_acc;
        end
        rev_rd_reg <= rev_mem[rev_raddr];
    end

    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        j_next       = j_reg;
        i_next       = i_reg;
        best_next    = best_reg;
        ovf_next     = ovf_reg;
        rd_vld_next  = 1'b0;
        rzero_next   = rzero_reg;
        m_valid_next = m_valid_reg && !m_tready;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    cnt_next  = base_cnt;
                    i_next    = CW'(1);
                    best_next = '0;
                    if (full) begin
                        j_next     = rcr_pkg::FULL_CNT;
                        ovf_next   = 1'b1;
                        state_next = ST_OUT;
                    end else begin
                        j_next     = base_cnt + CW'(1);
                        ovf_next   = 1'b0;
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                best_next   = best_acc;
                rd_vld_next = 1'b1;
                rzero_next  = (i_reg == j_reg);
                if (i_reg == j_reg) begin
                    state_next = ST_DRAIN;
                end else begin
                    i_next = i_reg + CW'(1);
                end
            end
            ST_DRAIN: begin
                best_next  = best_acc;
                cnt_next   = j_reg;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            rd_vld_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            rd_vld_reg  <= rd_vld_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        j_reg     <= j_next;
        i_reg     <= i_next;
        best_reg  <= best_next;
        ovf_reg   <= ovf_next;
        rzero_reg <= rzero_next;
        if (out_load) begin
            m_rev_reg <= best_reg;
            m_len_reg <= j_reg[rcr_pkg::LEN_W-1:0];
            m_ovf_reg <= ovf_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_ovf_reg;
    assign m_tdata  = {{(rcr_pkg::OUT_DATA_W - RW - rcr_pkg::LEN_W){1'b0}},
                       m_len_reg, m_rev_reg};

`ifndef SYNTH
    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= rcr_pkg::FULL_CNT)
        else $error("fill count beyond table size");

    a_scan_idx: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) |-> (i_reg >= CW'(1)) && (i_reg <= j_reg))
        else $error("scan index out of range");

    a_fill_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DRAIN) |=> (cnt_reg == $past(j_reg)))
        else $error("fill count not advanced after revenue write");

    a_ovf_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_ovf_reg) |-> (m_rev_reg == '0))
        else $error("dropped item carries a revenue");
`endif

endmodule
